// File: src/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

    localparam int CoordW = 16;
    localparam int TickW  = 16;
    localparam int CountW = 2;
    localparam int KindW  = 3;
    localparam int CfgIdxW = 2;

    localparam logic [CoordW-1:0] NO_COORD = {CoordW{1'b1}};
    localparam logic [TickW-1:0]  TICK_MAX = {TickW{1'b1}};

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SLIDE_DISTANCE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TAP_TICKS      = 2'd2;

    localparam logic [15:0] SLIDE_DISTANCE_RST = 16'd20;
    localparam logic [15:0] HOLD_TICKS_RST     = 16'd50;
    localparam logic [15:0] TAP_TICKS_RST      = 16'd2;

    // gesture kinds
    localparam logic [KindW-1:0] KIND_NONE  = 3'd0;
    localparam logic [KindW-1:0] KIND_TAP   = 3'd1;
    localparam logic [KindW-1:0] KIND_SWIPE = 3'd2;
    localparam logic [KindW-1:0] KIND_DRAG  = 3'd3;
    localparam logic [KindW-1:0] KIND_DROP  = 3'd4;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_DOWN  = 3'd1,
        PH_SLIDE = 3'd2,
        PH_HOLD  = 3'd3,
        PH_TWO   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] slide_distance;
        logic [15:0] hold_ticks;
        logic [15:0] tap_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [TickW-1:0]   down_ticks;
        logic [CoordW-1:0]  prev_x;
        logic [CoordW-1:0]  prev_y;
        logic [CoordW-1:0]  start_x;
        logic [CoordW-1:0]  start_y;
        logic [CoordW-1:0]  end_x;
        logic [CoordW-1:0]  end_y;
        logic [KindW-1:0]   kind;
    } gest_state_t;

    typedef struct packed {
        logic [CountW-1:0]  touch_count;
        logic [CoordW-1:0]  touch_x;
        logic [CoordW-1:0]  touch_y;
    } sample_t;

    localparam gest_state_t STATE_RST = '{
        phase:      PH_START,
        down_ticks: '0,
        prev_x:     NO_COORD,
        prev_y:     NO_COORD,
        start_x:    NO_COORD,
        start_y:    NO_COORD,
        end_x:      NO_COORD,
        end_y:      NO_COORD,
        kind:       KIND_NONE
    };

endpackage

// File: src/tgc_step.sv
`timescale 1ns / 1ps

// next-state logic of the gesture machine for one sample
module tgc_step
    import tgc_pkg::*;
(
    input  cfg_t        cfg,
    input  gest_state_t cur,
    input  sample_t     smp,
    output gest_state_t nxt,
    output logic        event_flag
);

    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              second;
    logic              cur_ok;
    logic              last_ok;
    logic [CoordW-1:0] dx_prev;
    logic [CoordW-1:0] dy_prev;
    logic [CoordW-1:0] dx_start;
    logic [CoordW-1:0] dy_start;
    logic              moved_prev;
    logic              moved_start;
    logic [TickW-1:0]  ticks_base;
    logic [TickW-1:0]  ticks_inc;

    assign cx      = (smp.touch_count != '0) ? smp.touch_x : NO_COORD;
    assign cy      = (smp.touch_count != '0) ? smp.touch_y : NO_COORD;
    assign second  = smp.touch_count[1];
    assign cur_ok  = (cx != NO_COORD) && (cy != NO_COORD);
    assign last_ok = (cur.prev_x != NO_COORD) && (cur.prev_y != NO_COORD);

    assign dx_prev  = (cx > cur.prev_x) ? cx - cur.prev_x : cur.prev_x - cx;
    assign dy_prev  = (cy > cur.prev_y) ? cy - cur.prev_y : cur.prev_y - cy;
    assign dx_start = (cx > cur.start_x) ? cx - cur.start_x : cur.start_x - cx;
    assign dy_start = (cy > cur.start_y) ? cy - cur.start_y : cur.start_y - cy;

    assign moved_prev  = (dx_prev > cfg.slide_distance) || (dy_prev > cfg.slide_distance);
    assign moved_start = (dx_start > cfg.slide_distance) || (dy_start > cfg.slide_distance);

    // a slide clears the counter before the increment
    assign ticks_base = moved_prev ? '0 : cur.down_ticks;
    assign ticks_inc  = (ticks_base == TICK_MAX) ? ticks_base : ticks_base + 1'b1;

    always_comb
    begin
        nxt        = cur;
        event_flag = 1'b0;
        nxt.prev_x = cx;
        nxt.prev_y = cy;
        unique case (cur.phase)
            PH_START:
            begin
                if (cur_ok)
                begin
                    nxt.phase      = second ? PH_TWO : PH_DOWN;
                    nxt.down_ticks = '0;
                    nxt.start_x    = cx;
                    nxt.start_y    = cy;
                end
            end
            PH_DOWN:
            begin
                if (cur_ok)
                begin
                    if (last_ok)
                    begin
                        nxt.down_ticks = ticks_inc;
                        if (moved_prev)
                        begin
                            nxt.start_x = cx;
                            nxt.start_y = cy;
                            nxt.phase   = PH_SLIDE;
                        end
                        if (ticks_inc >= cfg.hold_ticks)
                        begin
                            nxt.start_x    = cx;
                            nxt.start_y    = cy;
                            nxt.phase      = PH_HOLD;
                            nxt.down_ticks = '0;
                            nxt.kind       = KIND_DRAG;
                            event_flag     = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (cur.down_ticks >= cfg.tap_ticks)
                    begin
                        nxt.end_x  = cur.prev_x;
                        nxt.end_y  = cur.prev_y;
                        nxt.kind   = KIND_TAP;
                        event_flag = 1'b1;
                    end
                    nxt.phase      = PH_START;
                    nxt.down_ticks = '0;
                end
            end
            PH_SLIDE:
            begin
                if (!cur_ok || !moved_start)
                begin
                    nxt.end_x      = cur.prev_x;
                    nxt.end_y      = cur.prev_y;
                    nxt.kind       = KIND_SWIPE;
                    event_flag     = 1'b1;
                    nxt.phase      = PH_START;
                    nxt.down_ticks = '0;
                end
            end
            PH_HOLD:
            begin
                if (!cur_ok)
                begin
                    nxt.end_x      = cur.prev_x;
                    nxt.end_y      = cur.prev_y;
                    nxt.kind       = KIND_DROP;
                    event_flag     = 1'b1;
                    nxt.phase      = PH_START;
                    nxt.down_ticks = '0;
                end
            end
            default:
            begin
                // two fingers and any unused code fall back to start
                nxt.phase      = PH_START;
                nxt.down_ticks = '0;
            end
        endcase
    end

endmodule

// File: src/touch_gesture_classifier.sv
`timescale 1ns / 1ps

// a result is registered when its sample transaction is accepted and offered in the cycle after it
// throughput: one sample per cycle, limited only by the output register being taken
// the output register frees in the same cycle it is read, so back-to-back samples flow
// reset (rst_n low, asynchronous): machine to start, counters cleared, points absent,
// registers to their defaults (slide 20, hold 50, tap 2), output empty
module touch_gesture_classifier
    import tgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [15:0]          cfg_wdata,

    // sample stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // touch_count[1:0], touch_x[17:2], touch_y[33:18]

    // gesture stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // begin_x, begin_y, finish_x, finish_y
    output logic [3:0]           m_axis_tuser    // gesture_event[0], gesture_kind[3:1]
);

    cfg_t        cfg_reg;
    gest_state_t state_reg;
    gest_state_t state_next;
    sample_t     smp;
    logic        event_next;
    logic        accept;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [3:0]  out_user_reg;

    // unpack the sample transaction
    assign smp.touch_count = s_axis_tdata[1:0];
    assign smp.touch_x     = s_axis_tdata[17:2];
    assign smp.touch_y     = s_axis_tdata[33:18];

    // a new sample is taken whenever the result register is empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tgc_step u_step
    (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .smp        (smp),
        .nxt        (state_next),
        .event_flag (event_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slide_distance <= SLIDE_DISTANCE_RST;
            cfg_reg.hold_ticks     <= HOLD_TICKS_RST;
            cfg_reg.tap_ticks      <= TAP_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SLIDE_DISTANCE: cfg_reg.slide_distance <= cfg_wdata;
                CFG_HOLD_TICKS:     cfg_reg.hold_ticks     <= cfg_wdata;
                CFG_TAP_TICKS:      cfg_reg.tap_ticks      <= cfg_wdata;
                default:            ; // writes beyond the register list are dropped
            endcase
        end
    end

    // gesture state advances once per accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RST;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {state_next.end_y, state_next.end_x,
                             state_next.start_y, state_next.start_x};
            out_user_reg <= {state_next.kind, event_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// File: src/tgc_checker.sv
`timescale 1ns / 1ps

module tgc_checker
    import tgc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [3:0]          m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // every accepted sample yields a result on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted sample gave no result");

    // an empty result register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a recognized gesture always carries a real kind
    a_event_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tuser[3:1] == KIND_TAP) || (m_axis_tuser[3:1] == KIND_SWIPE) ||
            (m_axis_tuser[3:1] == KIND_DRAG) || (m_axis_tuser[3:1] == KIND_DROP))
        else $error("event without gesture kind");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);
